[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("implication check failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

[rtl/rgbar_pkg.sv]
// ----------------------------------------------------------------------------
// rgbar_pkg
// Shared types and constants of the rounded gradient bar pixel unit.
// ----------------------------------------------------------------------------
package rgbar_pkg;

  // largest texture the unit draws
  localparam int unsigned MAX_WIDTH  = 64;
  localparam int unsigned MAX_HEIGHT = 32;

  // fixed-point shift of the reciprocal table
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned RECIP_W     = 19;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_BAR_WIDTH    = 3'd0,
    REG_BAR_HEIGHT   = 3'd1,
    REG_TOP_COLOR    = 3'd2,
    REG_BOTTOM_COLOR = 3'd3,
    REG_BORDER_COLOR = 3'd4,
    REG_ROUNDED_ENDS = 3'd5,
    REG_STRIPED      = 3'd6
  } cfg_reg_t;

  // stage control handed from the top level to each color lane
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
    logic stripe4;
  } lane_ctl_t;

  // floor(2^18 / d) + 1; exact quotient for n * d < 2^18. d = 0 gives 0.
  function automatic logic [RECIP_W-1:0] recip(input logic [4:0] d);
    logic [RECIP_W-1:0] m;
    unique case (d)
      5'd1:    m = 19'd262145;
      5'd2:    m = 19'd131073;
      5'd3:    m = 19'd87382;
      5'd4:    m = 19'd65537;
      5'd5:    m = 19'd52429;
      5'd6:    m = 19'd43691;
      5'd7:    m = 19'd37450;
      5'd8:    m = 19'd32769;
      5'd9:    m = 19'd29128;
      5'd10:   m = 19'd26215;
      5'd11:   m = 19'd23832;
      5'd12:   m = 19'd21846;
      5'd13:   m = 19'd20165;
      5'd14:   m = 19'd18725;
      5'd15:   m = 19'd17477;
      5'd16:   m = 19'd16385;
      5'd17:   m = 19'd15421;
      5'd18:   m = 19'd14564;
      5'd19:   m = 19'd13798;
      5'd20:   m = 19'd13108;
      5'd21:   m = 19'd12484;
      5'd22:   m = 19'd11916;
      5'd23:   m = 19'd11398;
      5'd24:   m = 19'd10923;
      5'd25:   m = 19'd10486;
      5'd26:   m = 19'd10083;
      5'd27:   m = 19'd9710;
      5'd28:   m = 19'd9363;
      5'd29:   m = 19'd9040;
      5'd30:   m = 19'd8739;
      5'd31:   m = 19'd8457;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

[rtl/rgbar_lane.sv]
// ----------------------------------------------------------------------------
// rgbar_lane
// One color channel: vertical gradient through a reciprocal multiply, then
// the one-fifth lightening toward white for stripe columns.
// ----------------------------------------------------------------------------
module rgbar_lane (
  input  logic                                clk,
  input  rgbar_pkg::lane_ctl_t                ctl,
  input  logic [7:0]                          top_chan,
  input  logic [7:0]                          bot_chan,
  input  logic [4:0]                          y1,
  input  logic [rgbar_pkg::RECIP_W-1:0]       m2,
  output logic [7:0]                          lit
);
  import rgbar_pkg::*;

  logic [8:0]  diff;
  logic        neg;
  logic [7:0]  mag;
  logic [7:0]  q;
  logic [7:0]  c;
  logic [7:0]  room;

  // stage 2..4 registers
  logic [12:0] prod;
  logic        neg2;
  logic [7:0]  a2;
  logic [31:0] qm;
  logic        neg3;
  logic [7:0]  a3;
  logic [7:0]  c4;
  logic [15:0] lt4;

  // magnitude and sign of bottom - top
  assign diff = {1'b0, bot_chan} - {1'b0, top_chan};
  assign neg  = diff[8];
  assign mag  = neg ? 8'(-diff) : diff[7:0];

  // |b-a| * y
  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      prod <= 13'(mag * y1);
      neg2 <= neg;
      a2   <= top_chan;
    end
  end

  // divide by (height-1) as a reciprocal multiply
  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      qm   <= 32'(prod * m2);
      neg3 <= neg2;
      a3   <= a2;
    end
  end

  // apply signed quotient, then (255 - c) * 205 for the /5
  assign q    = qm[RECIP_SHIFT +: 8];
  assign c    = neg3 ? a3 - q : a3 + q;
  assign room = 8'hFF - c;

  always_ff @(posedge clk) begin
    if (ctl.en4) begin
      c4  <= c;
      lt4 <= 16'(room * 8'd205);
    end
  end

  // (room * 205) >> 10 equals room / 5 for room below 1024
  assign lit = ctl.stripe4 ? c4 + {2'b00, lt4[15:10]} : c4;

endmodule

[rtl/rounded_gradient_bar_pixel_unit.sv]
// ----------------------------------------------------------------------------
// rounded_gradient_bar_pixel_unit
// Takes one pixel coordinate per word and returns the RGBA color of a
// progress-bar texture: vertical gradient, optional rounded ends, optional
// stripes and a one-pixel border. The unit is a five-stage pipeline that
// accepts one pixel per clock while no output stall holds it; the per-stage
// ready chain lets a new pixel enter whenever any stage has room, so output
// stalls only stop the unit once all five stages are full. The gradient
// divide by (height-1) is a reciprocal table lookup and a 13x19 multiply;
// configuration writes are taken in any cycle and must only be issued while
// the pipeline is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rounded_gradient_bar_pixel_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // pixel coordinate channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  pixel_x,
  input  logic [4:0]  pixel_y,
  // color channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha
);
  import rgbar_pkg::*;

  // configuration registers
  logic [6:0]  bar_width;
  logic [5:0]  bar_height;
  logic [31:0] top_color;
  logic [31:0] bottom_color;
  logic [31:0] border_color;
  logic        rounded_ends;
  logic        striped;

  // pipeline valid bits and ready chain
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 1 coordinates
  logic [5:0] x1;
  logic [4:0] y1;

  // stage 1 geometry
  logic [6:0]  w_sat;
  logic [5:0]  h_sat;
  logic [4:0]  r;
  logic [6:0]  x7;
  logic [6:0]  r7;
  logic [5:0]  y6;
  logic [5:0]  r6;
  logic        left;
  logic        right_hit;
  logic [6:0]  dx;
  logic [5:0]  dy;
  logic [4:0]  dxm;
  logic [4:0]  dym;
  logic [10:0] dsq;
  logic        outside;
  logic        border;
  logic        stripe;
  logic [5:0]  dm1;

  // stage 2..4 flags
  logic        outside2, border2, stripe2, round2;
  logic [10:0] dsq2;
  logic [9:0]  rsq2;
  logic [RECIP_W-1:0] m2;
  logic        blank3, border3, stripe3;
  logic        blank4, border4, stripe4;

  lane_ctl_t   ctl;
  logic [7:0]  lit [4];

  // configuration writes; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_width    <= 7'd48;
      bar_height   <= 6'd18;
      top_color    <= '0;
      bottom_color <= '0;
      border_color <= '0;
      rounded_ends <= 1'b0;
      striped      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BAR_WIDTH:    bar_width    <= cfg_data[6:0];
        REG_BAR_HEIGHT:   bar_height   <= cfg_data[5:0];
        REG_TOP_COLOR:    top_color    <= cfg_data;
        REG_BOTTOM_COLOR: bottom_color <= cfg_data;
        REG_BORDER_COLOR: border_color <= cfg_data;
        REG_ROUNDED_ENDS: rounded_ends <= cfg_data[0];
        REG_STRIPED:      striped      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ready chain: a stage loads when empty or when the next one loads
  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: capture coordinates
  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1 <= pixel_x;
      y1 <= pixel_y;
    end
  end

  // saturated size and radius
  assign w_sat = (bar_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : bar_width;
  assign h_sat = (bar_height > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : bar_height;
  assign r     = h_sat[5:1];
  assign x7    = {1'b0, x1};
  assign r7    = {2'b00, r};
  assign y6    = {1'b0, y1};
  assign r6    = {1'b0, r};

  // distance to the end-circle centers
  assign left      = x7 < r7;
  assign right_hit = (x7 + r7) >= w_sat;
  assign dx        = left ? r7 - x7 - 7'd1 : x7 + r7 - w_sat;
  assign dy        = (y6 < r6) ? r6 - y6 - 6'd1 : y6 + 6'd1 - r6;
  assign dxm       = dx[4:0];
  assign dym       = dy[4:0];
  assign dsq       = 11'(dxm * dxm) + 11'(dym * dym);

  // region flags
  assign outside = (x7 >= w_sat) || (y6 >= h_sat);
  assign border  = (y1 == 5'd0) || (y6 == h_sat - 6'd1) ||
                   (x1 == 6'd0) || (x7 == w_sat - 7'd1);
  assign stripe  = striped && !x1[2] && (x7 > r7) && ((x7 + r7) < w_sat);
  assign dm1     = h_sat - 6'd1;

  // stage 2: squares, flags, reciprocal of height-1
  always_ff @(posedge clk) begin
    if (rdy2) begin
      outside2 <= outside;
      border2  <= border;
      stripe2  <= stripe;
      round2   <= rounded_ends && (left || right_hit);
      dsq2     <= dsq;
      rsq2     <= 10'(r * r);
      m2       <= recip(dm1[4:0]);
    end
  end

  // stage 3: circle test
  always_ff @(posedge clk) begin
    if (rdy3) begin
      blank3  <= outside2 || (round2 && (dsq2 > {1'b0, rsq2}));
      border3 <= border2;
      stripe3 <= stripe2;
    end
  end

  // stage 4: flags alongside the lane result
  always_ff @(posedge clk) begin
    if (rdy4) begin
      blank4  <= blank3;
      border4 <= border3;
      stripe4 <= stripe3;
    end
  end

  assign ctl.en2     = rdy2;
  assign ctl.en3     = rdy3;
  assign ctl.en4     = rdy4;
  assign ctl.stripe4 = stripe4;

  // one lane per channel, R G B A from the top byte down
  for (genvar k = 0; k < 4; k++) begin : g_lane
    rgbar_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .top_chan (top_color[31 - 8*k -: 8]),
      .bot_chan (bottom_color[31 - 8*k -: 8]),
      .y1       (y1),
      .m2       (m2),
      .lit      (lit[k])
    );
  end

  // stage 5: blank, border or shaded color
  always_ff @(posedge clk) begin
    if (rdy5) begin
      if (blank4) begin
        red   <= '0;
        green <= '0;
        blue  <= '0;
        alpha <= '0;
      end else if (border4) begin
        red   <= border_color[31:24];
        green <= border_color[23:16];
        blue  <= border_color[15:8];
        alpha <= border_color[7:0];
      end else begin
        red   <= lit[0];
        green <= lit[1];
        blue  <= lit[2];
        alpha <= lit[3];
      end
    end
  end

  assign out_valid = v5;

  // checks
  `ASSERT_IMPLY(a_ready_chain, clk, rst, out_ready, in_ready)
  `ASSERT_NEXT(a_blank_zero, clk, rst, v4 && rdy5 && blank4,
               out_valid && red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0)
  `ASSERT_NEXT(a_stage_move, clk, rst, v4 && rdy5, out_valid)

endmodule
